// ===== sv/pltb_pkg.sv =====
`default_nettype none
package pltb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_OUT        = 16;
  localparam int SLOT_W         = 4;
  localparam int VAL_W          = 16;
  localparam int STEP_W         = 15;
  localparam int PER_W          = 16;
  localparam int ACC_W          = 17;
  localparam int TIME_W         = 32;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_BREAK = 2'd2,
    OP_CONT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_FIRED   = 3'd0,
    K_STARTED = 3'd1,
    K_FULL    = 3'd2,
    K_PAUSED  = 3'd3,
    K_CLEARED = 3'd4,
    K_RESUMED = 3'd5,
    K_IGNORED = 3'd6
  } kind_t;

  // One timer slot as held in the slot memory.
  typedef struct packed {
    logic [VAL_W-1:0]  start_v;
    logic [VAL_W-1:0]  end_v;
    logic [STEP_W-1:0] step;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  elapsed;
    logic [ACC_W-1:0]  value;
    logic              has_cmd;
  } slot_rec_t;

endpackage
`default_nettype wire

// ===== sv/periodic_loop_timer_bank.sv =====
// Bank of periodic loop timers, slot records in one synchronous memory.
// Start, break and continue: result strobed in the cycle after acceptance; the
//   next item may be accepted in that same cycle (one item per cycle).
// Tick with a new time stamp: busy while every slot is scanned, one slot read per
//   cycle; the result marked last, if any, comes in the same cycle that busy drops.
// No receiver stall. Reset (rst_n low, sync) empties every slot, zeroes time.
`default_nettype none
module periodic_loop_timer_bank
  import pltb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [1:0]               in_op,
  input  wire logic signed [VAL_W-1:0]  in_start_value,
  input  wire logic signed [VAL_W-1:0]  in_end_value,
  input  wire logic [STEP_W-1:0]        in_step_size,
  input  wire logic [PER_W-1:0]         in_period_ticks,
  input  wire logic                     in_has_command,
  input  wire logic [SLOT_W-1:0]        in_timer_id,
  input  wire logic [TIME_W-1:0]        in_tick_time,
  output      logic                     out_strobe,
  output      logic [2:0]               out_kind,
  output      logic [SLOT_W-1:0]        out_slot,
  output      logic signed [VAL_W-1:0]  out_loop_value,
  output      logic                     out_finished,
  output      logic                     out_last
);

  localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW  = $clog2(NUM_TIMERS + 1);
  localparam int IXW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int RCW = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t state_r;

  // Per-slot status flags. valid_r marks a memory entry that holds a written
  // record; an entry without it reads as all zero (a wiped slot).
  logic [NUM_TIMERS-1:0] act_r;
  logic [NUM_TIMERS-1:0] work_r;
  logic [NUM_TIMERS-1:0] valid_r;

  logic [TIME_W-1:0] prev_time_r;

  // Slot memory, one read and one write port.
  slot_rec_t mem [NUM_TIMERS];
  slot_rec_t rdata_r;
  logic      mem_we;
  logic [IW-1:0] mem_waddr;
  slot_rec_t mem_wdata;
  logic [IW-1:0] mem_raddr;

  // Scan control: cnt_r is the slot being read, p_idx_r the slot whose
  // record arrives this cycle.
  logic [CW-1:0]  cnt_r;
  logic           p_valid_r;
  logic [IW-1:0]  p_idx_r;
  logic           rd_ok_r;
  logic [RCW-1:0] res_cnt_r;

  // One firing held back so the final one of a tick can carry last.
  logic              pend_valid_r;
  logic [IW-1:0]     pend_slot_r;
  logic [VAL_W-1:0]  pend_value_r;
  logic              pend_fin_r;

  // Registered result.
  logic              out_strobe_r;
  kind_t             out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_fin_r;
  logic              out_last_r;

  logic accept;
  op_t  op;
  assign accept = start && (state_r == S_IDLE);
  assign op     = op_t'(in_op);

  // Lowest slot that is neither running nor resumable.
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!act_r[i] && !work_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // New record for a start.
  slot_rec_t     new_rec;
  logic          new_work;
  logic [IW-1:0] id_ix;
  logic          id_ok;
  always_comb begin
    new_rec.start_v = in_start_value;
    new_rec.end_v   = in_end_value;
    new_rec.step    = (in_step_size == '0) ? STEP_W'(1) : in_step_size;
    new_rec.period  = in_period_ticks;
    new_rec.elapsed = in_period_ticks - PER_W'(1);
    new_rec.value   = {in_start_value[VAL_W-1], in_start_value};
    new_rec.has_cmd = in_has_command;
    new_work = ((in_start_value != '0) || (in_end_value != '0)) && in_has_command;
    id_ok    = int'(in_timer_id) < NUM_TIMERS;
    id_ix    = IW'(in_timer_id);
  end

  // Per-slot update on a counting tick.
  slot_rec_t        rec;
  slot_rec_t        upd_rec;
  logic [ACC_W-1:0] e_nxt;
  logic             fire;
  logic             count_up;
  logic [ACC_W-1:0] v_nxt;
  logic [ACC_W-1:0] end_x;
  logic             done;
  always_comb begin
    rec      = rd_ok_r ? rdata_r : '0;
    e_nxt    = {1'b0, rec.elapsed} + ACC_W'(1);
    fire     = e_nxt >= {1'b0, rec.period};
    count_up = $signed(rec.start_v) < $signed(rec.end_v);
    end_x    = {rec.end_v[VAL_W-1], rec.end_v};
    if (count_up) begin
      v_nxt = rec.value + {2'b00, rec.step};
      done  = $signed(v_nxt) > $signed(end_x);
    end else begin
      v_nxt = rec.value - {2'b00, rec.step};
      done  = $signed(v_nxt) < $signed(end_x);
    end
    upd_rec = rec;
    if (fire) begin
      upd_rec.elapsed = '0;
      upd_rec.value   = v_nxt;
    end else begin
      upd_rec.elapsed = e_nxt[PER_W-1:0];
    end
  end

  logic fire_now;
  assign fire_now = (state_r == S_SCAN) && p_valid_r && act_r[p_idx_r] && fire;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = new_rec;
    mem_raddr = cnt_r[IW-1:0];
    if (accept && (op == OP_START) && (in_period_ticks != '0) && free_found) begin
      mem_we = 1'b1;
    end else if ((state_r == S_SCAN) && p_valid_r && act_r[p_idx_r]) begin
      mem_we    = 1'b1;
      mem_waddr = p_idx_r;
      mem_wdata = upd_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Slot index to the 4-bit result field.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IW-1:0] ix);
    logic [IXW-1:0] w;
    w = IXW'(ix);
    return w[SLOT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      act_r        <= '0;
      work_r       <= '0;
      valid_r      <= '0;
      prev_time_r  <= '0;
      cnt_r        <= '0;
      p_valid_r    <= 1'b0;
      res_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            // Non-tick ops answer with a single result.
            out_kind_r  <= K_IGNORED;
            out_slot_r  <= '0;
            out_value_r <= '0;
            out_fin_r   <= 1'b0;
            out_last_r  <= 1'b1;
            unique case (op)
              OP_START: begin
                out_strobe_r <= 1'b1;
                if (in_period_ticks == '0) begin
                  out_kind_r <= K_IGNORED;
                end else if (!free_found) begin
                  out_kind_r <= K_FULL;
                end else begin
                  act_r[free_idx]   <= 1'b1;
                  work_r[free_idx]  <= new_work;
                  valid_r[free_idx] <= 1'b1;
                  out_kind_r        <= K_STARTED;
                  out_slot_r        <= slot_of(free_idx);
                end
              end
              OP_TICK: begin
                // Same time stamp as before: no count, no result.
                if (in_tick_time != prev_time_r) begin
                  prev_time_r  <= in_tick_time;
                  state_r      <= S_SCAN;
                  cnt_r        <= '0;
                  p_valid_r    <= 1'b0;
                  res_cnt_r    <= '0;
                  pend_valid_r <= 1'b0;
                end
              end
              OP_BREAK: begin
                out_strobe_r <= 1'b1;
                out_slot_r   <= in_timer_id;
                if (!id_ok) begin
                  out_kind_r <= K_IGNORED;
                end else if (act_r[id_ix]) begin
                  act_r[id_ix] <= 1'b0;
                  out_kind_r   <= K_PAUSED;
                end else begin
                  valid_r[id_ix] <= 1'b0;
                  work_r[id_ix]  <= 1'b0;
                  out_kind_r     <= K_CLEARED;
                end
              end
              OP_CONT: begin
                out_strobe_r <= 1'b1;
                out_slot_r   <= in_timer_id;
                if (id_ok && !act_r[id_ix] && work_r[id_ix]) begin
                  act_r[id_ix] <= 1'b1;
                  out_kind_r   <= K_RESUMED;
                end else begin
                  out_kind_r <= K_IGNORED;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue the read of the next slot.
          if (cnt_r != CW'(NUM_TIMERS)) begin
            p_valid_r <= 1'b1;
            p_idx_r   <= cnt_r[IW-1:0];
            rd_ok_r   <= valid_r[cnt_r[IW-1:0]];
            cnt_r     <= cnt_r + CW'(1);
          end else begin
            p_valid_r <= 1'b0;
            state_r   <= S_FLUSH;
          end
          // Handle a firing of the slot whose record just came back; retire it if done.
          if (fire_now) begin
            if (done) begin
              act_r[p_idx_r]   <= 1'b0;
              work_r[p_idx_r]  <= 1'b0;
              valid_r[p_idx_r] <= 1'b0;
            end
            if (res_cnt_r < RCW'(MAX_OUT)) begin
              res_cnt_r <= res_cnt_r + RCW'(1);
              if (pend_valid_r) begin
                out_strobe_r <= 1'b1;
                out_kind_r   <= K_FIRED;
                out_slot_r   <= slot_of(pend_slot_r);
                out_value_r  <= pend_value_r;
                out_fin_r    <= pend_fin_r;
                out_last_r   <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_slot_r  <= p_idx_r;
              pend_value_r <= rec.value[VAL_W-1:0];
              pend_fin_r   <= done;
            end
          end
        end
        S_FLUSH: begin
          // Final firing of the tick goes out marked last.
          if (pend_valid_r) begin
            out_strobe_r <= 1'b1;
            out_kind_r   <= K_FIRED;
            out_slot_r   <= slot_of(pend_slot_r);
            out_value_r  <= pend_value_r;
            out_fin_r    <= pend_fin_r;
            out_last_r   <= 1'b1;
          end
          pend_valid_r <= 1'b0;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_kind       = out_kind_r;
  assign out_slot       = out_slot_r;
  assign out_loop_value = out_value_r;
  assign out_finished   = out_fin_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ===== sv/pltb_checker.sv =====
`default_nettype none
module pltb_checker
  import pltb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [1:0]        in_op,
  input wire logic              out_strobe,
  input wire logic [2:0]        out_kind,
  input wire logic [SLOT_W-1:0] out_slot,
  input wire logic [VAL_W-1:0]  out_loop_value,
  input wire logic              out_finished,
  input wire logic              out_last
);

  // Start, break and continue answer in the next cycle with one last item.
  a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op != OP_TICK)) |=> (out_strobe && out_last))
    else $error("non-tick item did not answer next cycle");

  a_non_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_kind != K_FIRED)) |->
      ((out_loop_value == '0) && !out_finished && out_last))
    else $error("non-firing result carries value, finish or no last");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_kind == K_FULL)) |-> (out_slot == '0))
    else $error("full result names a slot");

  a_fired_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_kind == K_FIRED)) |-> $past(busy))
    else $error("firing reported outside a tick scan");

endmodule

bind periodic_loop_timer_bank pltb_checker u_pltb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .out_strobe     (out_strobe),
  .out_kind       (out_kind),
  .out_slot       (out_slot),
  .out_loop_value (out_loop_value),
  .out_finished   (out_finished),
  .out_last       (out_last)
);
`default_nettype wire
